### sv/varint_field_decoder_top_macros.svh
// Assertion helpers shared by the decoder's checking code.
`ifndef VARINT_FIELD_DECODER_TOP_MACROS_SVH
`define VARINT_FIELD_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vfd_pkg.sv
`default_nettype none

package vfd_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 10;
    localparam int QUEUE_DEPTH_DEF      = 4;
    localparam int SIZE_W               = 31;

    // Field kinds on the input side.
    localparam logic [1:0] FUNC_VARINT32 = 2'd0;
    localparam logic [1:0] FUNC_VARINT64 = 2'd1;
    localparam logic [1:0] FUNC_LENGTH   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_VARINT = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERLONG = 2'd1;
    localparam logic [1:0] ERR_BAD_LEN  = 2'd2;
    localparam logic [1:0] ERR_PAST_END = 2'd3;

    // Register index of buffer_size on the configuration port.
    localparam logic REG_BUFFER_SIZE = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_VARINT  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic        last;
        logic [1:0]  err;
    } vfd_result_t;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

`default_nettype wire

### sv/vfd_parser.sv
`default_nettype none

module vfd_parser import vfd_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic [1:0]        func,
    input  wire logic              buffer_start,
    input  wire logic [SIZE_W-1:0] buffer_size,
    output logic                   push,
    output vfd_result_t            result
);

    phase_t             phase_reg, phase_next, phase_cur;
    logic [63:0]        acc_reg, acc_next, acc_cur, acc_new;
    logic [3:0]         gc_reg, gc_next, gc_cur, gc_new;
    logic [1:0]         kind_reg, kind_next, kind_cur;
    logic [SIZE_W-1:0]  rem_reg, rem_next, rem_dec;
    logic [SIZE_W-1:0]  pos_reg, pos_next, pos_cur, pos_inc;
    logic [SIZE_W-1:0]  room;
    logic [6:0]         shamt_full;
    logic [31:0]        len32;
    logic               len_bad;

    always_comb
    begin
        phase_cur  = buffer_start ? PH_IDLE : phase_reg;
        pos_cur    = buffer_start ? '0 : pos_reg;
        acc_cur    = (phase_cur == PH_IDLE) ? '0 : acc_reg;
        gc_cur     = (phase_cur == PH_IDLE) ? '0 : gc_reg;
        kind_cur   = (phase_cur != PH_IDLE) ? kind_reg :
                     (func == FUNC_UNUSED)  ? FUNC_VARINT64 : func;
        shamt_full = {3'b000, gc_cur} * 7'd7;
        acc_new    = acc_cur | ({56'b0, 1'b0, data_byte[6:0]} << shamt_full[5:0]);
        gc_new     = gc_cur + 4'd1;
        pos_inc    = pos_cur + 1'b1;
        rem_dec    = rem_reg - 1'b1;
        len32      = acc_new[31:0];
        // A byte is only consumed when pos_cur < buffer_size, so this never wraps.
        room       = buffer_size - pos_inc;
        len_bad    = len32[31] || (len32[SIZE_W-1:0] > room);
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        gc_next    = gc_reg;
        kind_next  = kind_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        push       = 1'b0;
        result     = '0;
        result.last = 1'b1;
        if (accept)
        begin
            phase_next = phase_cur;
            acc_next   = acc_cur;
            gc_next    = gc_cur;
            kind_next  = kind_cur;
            pos_next   = pos_cur;
            if (pos_cur >= buffer_size)
            begin
                phase_next  = PH_IDLE;
                acc_next    = '0;
                gc_next     = '0;
                rem_next    = '0;
                push        = 1'b1;
                result.kind = KIND_ERROR;
                result.err  = ERR_PAST_END;
            end
            else
            begin
                pos_next = pos_inc;
                unique case (phase_cur) inside
                    PH_PAYLOAD:
                    begin
                        push         = 1'b1;
                        result.kind  = KIND_BYTE;
                        result.value = {56'b0, data_byte};
                        if (rem_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            rem_next   = '0;
                        end
                        else
                        begin
                            rem_next    = rem_dec;
                            result.last = 1'b0;
                        end
                    end
                    PH_IDLE, PH_VARINT:
                    begin
                        acc_next   = acc_new;
                        gc_next    = gc_new;
                        phase_next = PH_VARINT;
                        if (data_byte[7])
                        begin
                            if (gc_new >= 4'(MAX_VARINT_BYTES))
                            begin
                                phase_next  = PH_IDLE;
                                acc_next    = '0;
                                gc_next     = '0;
                                rem_next    = '0;
                                push        = 1'b1;
                                result.kind = KIND_ERROR;
                                result.err  = ERR_OVERLONG;
                            end
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            acc_next   = '0;
                            gc_next    = '0;
                            rem_next   = '0;
                            push       = 1'b1;
                            unique case (kind_cur)
                                FUNC_VARINT32:
                                begin
                                    result.kind  = KIND_VARINT;
                                    result.value = sext32(acc_new);
                                end
                                FUNC_VARINT64:
                                begin
                                    result.kind  = KIND_VARINT;
                                    result.value = acc_new;
                                end
                                default:
                                begin
                                    if (len_bad)
                                    begin
                                        result.kind = KIND_ERROR;
                                        result.err  = ERR_BAD_LEN;
                                    end
                                    else if (len32 == '0)
                                    begin
                                        result.kind = KIND_EMPTY;
                                    end
                                    else
                                    begin
                                        push       = 1'b0;
                                        rem_next   = len32[SIZE_W-1:0];
                                        phase_next = PH_PAYLOAD;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            gc_reg    <= '0;
            kind_reg  <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            gc_reg    <= gc_next;
            kind_reg  <= kind_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

### sv/vfd_queue.sv
`default_nettype none

module vfd_queue import vfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire vfd_result_t                push_data,
    input  wire logic                       pop,
    output logic                            not_full,
    output logic                            not_empty,
    output vfd_result_t                     head,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    vfd_result_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/varint_field_decoder_top.sv
// Serialized-field decoder. Bytes of a buffer arrive one word per cycle on the
// s_axis channel while tready is high; tuser carries the field kind (sampled on a
// field's first byte) and a flag that opens a new buffer. Each varint, each payload
// byte of a length-delimited field, each empty payload and each error leaves as one
// word on the m_axis channel, with tlast set on the word that completes a field.
// The buffer length is set through the APB register at address 0; the user must
// set it only while the block is idle, which the block itself does not enforce.
// Throughput is one input word per cycle while the queue has room: the parser does
// its shift-or update, stop-bit test and length check for a byte combinationally. A
// result is written into the queue at the edge that accepted its byte. Results wait
// in a queue of QUEUE_DEPTH words; when the receiver stalls the queue fills and
// s_axis_tready drops only once it is full, so no word is lost.
// Reset clears the parse state, the byte position, the queue and the buffer
// length; with a buffer length of zero every byte reports a read past the end.
`default_nettype none

module varint_field_decoder_top import vfd_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [2:0]  s_axis_tuser,   // [1:0] func, [2] buffer_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] value
    output logic             m_axis_tlast,   // last_of_field
    output logic [3:0]       m_axis_tuser,   // [1:0] result_kind, [3:2] error_code
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "varint_field_decoder_top_macros.svh"

    logic [SIZE_W-1:0]               buffer_size_reg, buffer_size_next;
    logic                            cfg_write;
    logic                            in_accept;
    logic                            res_push;
    vfd_result_t                     res_data;
    vfd_result_t                     head;
    logic                            q_not_full;
    logic                            q_not_empty;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_SIZE);
    assign prdata    = (paddr[2] == REG_BUFFER_SIZE) ? {1'b0, buffer_size_reg} : '0;

    always_comb
    begin
        buffer_size_next = buffer_size_reg;
        if (cfg_write)
        begin
            buffer_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= '0;
        end
        else
        begin
            buffer_size_reg <= buffer_size_next;
        end
    end

    assign s_axis_tready = q_not_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    vfd_parser #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .data_byte    (s_axis_tdata),
        .func         (s_axis_tuser[1:0]),
        .buffer_start (s_axis_tuser[2]),
        .buffer_size  (buffer_size_reg),
        .push         (res_push),
        .result       (res_data)
    );

    vfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (m_axis_tready),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head      (head),
        .level     (q_level)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = head.value;
    assign m_axis_tlast  = head.last;
    assign m_axis_tuser  = {head.err, head.kind};

    `VFD_ASSERT_SAME(a_only_bytes_continue, m_axis_tvalid && (m_axis_tuser[1:0] != KIND_BYTE),
        m_axis_tlast, "non-payload result without tlast")

    `VFD_ASSERT_SAME(a_err_matches_kind, m_axis_tvalid,
        ((m_axis_tuser[1:0] == KIND_ERROR) == (m_axis_tuser[3:2] != ERR_NONE)),
        "error code does not match result kind")

    `VFD_ASSERT_NEXT(a_no_result_without_input, !in_accept, q_level <= $past(q_level),
        "queue grew without an accepted input word")

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench import vfd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_GROUPS     = MAX_VARINT_BYTES_DEF;
    localparam int          RANDOM_WORDS   = 1950;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 4;
    localparam logic [30:0] SIZE_MAX       = 31'h7fff_ffff;
    localparam logic [2:0]  SIZE_ADDR      = 3'(4 * int'(REG_BUFFER_SIZE));

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] fn;
        logic       start;
    } in_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [2:0]  s_axis_tuser = '0;   // [1:0] func, [2] buffer_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [63:0] value
    logic        m_axis_tlast;        // last_of_field
    logic [3:0]  m_axis_tuser;        // [1:0] result_kind, [3:2] error_code
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the decoder state used to predict its results.
    logic [30:0] cfg_buffer_size;
    logic [63:0] shift_acc;
    logic [3:0]  group_cnt;
    phase_t      parse_st;
    logic [1:0]  field_func;
    logic [30:0] payload_left;
    logic [30:0] read_pos;

    vfd_result_t expected_results[$];
    in_word_t    word_q[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          sender_gaps = 1'b0;
    bit          receiver_stalls = 1'b0;

    varint_field_decoder_top #(
        .MAX_VARINT_BYTES(MAX_GROUPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] sign_widen(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] rand_bits(input int w);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (w < 64)
            v = v & ((64'd1 << w) - 64'd1);
        return v;
    endfunction

    function automatic int pad_extra();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    function automatic void clear_parse();
        parse_st     = PH_IDLE;
        shift_acc    = '0;
        group_cnt    = '0;
        payload_left = '0;
    endfunction

    function automatic vfd_result_t make_result(input logic [1:0] kind, input logic [63:0] value,
                                                input logic last, input logic [1:0] err);
        vfd_result_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        r.err   = err;
        return r;
    endfunction

    // Advances the shadow parser by one accepted byte; returns 1 when a result is due.
    function automatic bit predict_decode(input in_word_t w, output vfd_result_t res);
        logic [63:0] len;
        logic [30:0] room;
        int          shift;
        res = '0;
        if (w.start)
        begin
            read_pos = '0;
            clear_parse();
        end
        if (read_pos >= cfg_buffer_size)
        begin
            clear_parse();
            res = make_result(KIND_ERROR, '0, 1'b1, ERR_PAST_END);
            return 1'b1;
        end
        read_pos = read_pos + 31'd1;

        if (parse_st == PH_PAYLOAD)
        begin
            payload_left = payload_left - 31'd1;
            res = make_result(KIND_BYTE, {56'd0, w.data}, payload_left == '0, ERR_NONE);
            if (payload_left == '0)
                clear_parse();
            return 1'b1;
        end

        if (parse_st == PH_IDLE)
        begin
            field_func = (w.fn == FUNC_UNUSED) ? FUNC_VARINT64 : w.fn;
            shift_acc  = '0;
            group_cnt  = '0;
            parse_st   = PH_VARINT;
        end

        shift = (7 * int'(group_cnt)) % 64;
        shift_acc = shift_acc | ({57'd0, w.data[6:0]} << shift);
        group_cnt = group_cnt + 4'd1;

        if (w.data[7])
        begin
            if (int'(group_cnt) >= MAX_GROUPS)
            begin
                clear_parse();
                res = make_result(KIND_ERROR, '0, 1'b1, ERR_OVERLONG);
                return 1'b1;
            end
            return 1'b0;
        end

        if (field_func != FUNC_LENGTH)
        begin
            res = make_result(KIND_VARINT,
                              (field_func == FUNC_VARINT32) ? sign_widen(shift_acc) : shift_acc,
                              1'b1, ERR_NONE);
            clear_parse();
            return 1'b1;
        end

        // Length prefix: negative or larger than what is left of the buffer is rejected.
        len  = sign_widen(shift_acc);
        room = (cfg_buffer_size >= read_pos) ? cfg_buffer_size - read_pos : '0;
        if (len[63] || len > {33'd0, room})
        begin
            clear_parse();
            res = make_result(KIND_ERROR, '0, 1'b1, ERR_BAD_LEN);
            return 1'b1;
        end
        if (len == '0)
        begin
            clear_parse();
            res = make_result(KIND_EMPTY, '0, 1'b1, ERR_NONE);
            return 1'b1;
        end
        shift_acc    = '0;
        group_cnt    = '0;
        payload_left = len[30:0];
        parse_st     = PH_PAYLOAD;
        return 1'b0;
    endfunction

    task automatic send_word(input logic [7:0] data, input logic [1:0] fn, input logic start);
        in_word_t    w;
        vfd_result_t res;
        w.data  = data;
        w.fn    = fn;
        w.start = start;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {start, fn};
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        if (predict_decode(w, res))
            expected_results.push_back(res);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // A word that yields no result may still be in the parser.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= SIZE_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_size_reg(input logic [30:0] want);
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {1'b0, want})
        begin
            $display("%0t: buffer_size readback expected %h actual %h", $time, {1'b0, want}, rd);
            mismatches++;
        end
    endtask

    task automatic set_buffer_size(input logic [30:0] size);
        logic [31:0] rd;
        apb_access(1'b1, {1'b0, size}, rd);
        cfg_buffer_size = size;
        check_size_reg(size);
    endtask

    task automatic queue_word(input logic [7:0] data, input logic [1:0] fn, input logic start);
        in_word_t w;
        w.data  = data;
        w.fn    = fn;
        w.start = start;
        word_q.push_back(w);
    endtask

    task automatic flush_words();
        in_word_t w;
        while (word_q.size() != 0)
        begin
            w = word_q.pop_front();
            send_word(w.data, w.fn, w.start);
        end
    endtask

    // Encodes v low group first, optionally padded with empty groups.
    task automatic queue_varint(input logic [63:0] v, input int extra, input logic [1:0] fn,
                                input logic start, output int n);
        logic [63:0] rest;
        logic [7:0]  b;
        n = 1;
        rest = v >> 7;
        while (rest != '0)
        begin
            n++;
            rest = rest >> 7;
        end
        n = (n + extra > MAX_GROUPS) ? MAX_GROUPS : n + extra;
        for (int i = 0; i < n; i++)
        begin
            b[6:0] = 7'(v >> (7 * i));
            b[7]   = (i < n - 1);
            // Bits of the tenth group above bit 63 must be dropped.
            if (i == 9 && $urandom_range(0, 3) == 0)
                b[6:1] = 6'($urandom);
            if (i == 0)
                queue_word(b, fn, start);
            else
                queue_word(b, 2'($urandom), 1'b0);
        end
    endtask

    task automatic add_random_field(input int target, input logic start, inout int used);
        int          r;
        int          n;
        int          len;
        int          room;
        logic [31:0] v32;
        logic [63:0] neg;
        logic [1:0]  fn;
        r = $urandom_range(0, 99);
        if (r < 28)
        begin
            v32 = 32'(rand_bits($urandom_range(1, 32)));
            if (v32[31] && $urandom_range(0, 3) != 0)
                queue_varint({{32{v32[31]}}, v32}, 0, FUNC_VARINT32, start, n);
            else
                queue_varint({32'd0, v32}, pad_extra(), FUNC_VARINT32, start, n);
        end
        else if (r < 50)
        begin
            fn = ($urandom_range(0, 4) == 0) ? FUNC_UNUSED : FUNC_VARINT64;
            queue_varint(rand_bits($urandom_range(1, 64)), pad_extra(), fn, start, n);
        end
        else if (r < 85)
        begin
            room = target - used - 1;
            case ($urandom_range(0, 9))
                7:       len = room;
                8:       len = room + 1 + $urandom_range(0, 3);
                9:       len = -1;
                default:
                begin
                    len = $urandom_range(0, 6);
                    if (room >= 0 && len > room)
                        len = room;
                end
            endcase
            if (len < 0)
            begin
                neg = -64'($urandom_range(1, 1000));
                if ($urandom_range(0, 1) == 0)
                    neg = {32'd0, neg[31:0]};
                queue_varint(neg, 0, FUNC_LENGTH, start, n);
            end
            else
            begin
                queue_varint(64'(len), 0, FUNC_LENGTH, start, n);
                if (len <= room)
                begin
                    repeat (len) queue_word(8'($urandom), 2'($urandom), 1'b0);
                    n += len;
                end
            end
        end
        else if (r < 93)
        begin
            n = MAX_GROUPS;
            for (int i = 0; i < n; i++)
                queue_word({1'b1, 7'($urandom)}, 2'($urandom), (i == 0) ? start : 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                queue_word(8'($urandom), 2'($urandom),
                           (i == 0) ? start : ($urandom_range(0, 7) == 0));
        end
        used += n;
    endtask

    task automatic build_buffer(input int target);
        int   used;
        logic first;
        used  = 0;
        first = 1'b1;
        while (used < target)
        begin
            add_random_field(target, first, used);
            first = 1'b0;
        end
        // Sometimes run on past the end of the buffer.
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) queue_word(8'($urandom), 2'($urandom), 1'b0);
    endtask

    task automatic check_empty_buffer();
        check_size_reg('0);
        send_word(8'h80, FUNC_VARINT32, 1'b1);
        wait_for_results();
    endtask

    task automatic check_field_kinds();
        set_buffer_size(31'd12);
        send_word(8'h00, FUNC_LENGTH, 1'b1);
        send_word(8'h7f, FUNC_UNUSED, 1'b0);
        repeat (4) send_word(8'hff, FUNC_VARINT32, 1'b0);
        send_word(8'h0f, FUNC_VARINT32, 1'b0);
        send_word(8'h02, FUNC_LENGTH, 1'b0);
        send_word(8'h00, FUNC_LENGTH, 1'b0);
        send_word(8'hff, FUNC_LENGTH, 1'b0);
        // This length exactly fills what is left of the buffer.
        send_word(8'h01, FUNC_LENGTH, 1'b0);
        send_word(8'h80, FUNC_LENGTH, 1'b0);
        send_word(8'h5a, FUNC_VARINT32, 1'b0);
        wait_for_results();
    endtask

    task automatic check_length_limits();
        set_buffer_size(31'd8);
        send_word(8'h08, FUNC_LENGTH, 1'b1);
        send_word(8'h05, FUNC_LENGTH, 1'b1);
        send_word(8'h11, FUNC_LENGTH, 1'b0);
        // A new buffer opened in the middle of a payload.
        send_word(8'h7f, FUNC_VARINT32, 1'b1);
        wait_for_results();
    endtask

    task automatic check_size_change_mid_field();
        set_buffer_size(31'd8);
        send_word(8'h03, FUNC_LENGTH, 1'b1);
        send_word(8'haa, FUNC_LENGTH, 1'b0);
        wait_for_results();
        set_buffer_size(31'd2);
        send_word(8'h55, FUNC_VARINT64, 1'b0);
        wait_for_results();
    endtask

    task automatic check_overlong_varint();
        set_buffer_size(SIZE_MAX);
        for (int i = 0; i < MAX_GROUPS; i++)
            send_word(8'hff, FUNC_VARINT64, i == 0);
        wait_for_results();
    endtask

    task automatic check_random_buffers();
        int          first_word;
        int          target;
        int          c;
        logic [30:0] size;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS)
        begin
            target = $urandom_range(1, 48);
            c = $urandom_range(0, 19);
            if (c < 14)
                size = 31'(target);
            else if (c < 17)
                size = 31'(target + $urandom_range(0, 6) - 3);
            else if (c < 19)
                size = SIZE_MAX;
            else
                size = '0;
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            set_buffer_size(size);
            repeat ($urandom_range(1, 3)) build_buffer(target);
            flush_words();
            wait_for_results();
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 4) == 0)
        begin
            stall_left = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        vfd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word expected none actual kind %0d value %h",
                         $time, m_axis_tuser[1:0], m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser[1:0] !== want.kind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, want.kind, m_axis_tuser[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata !== want.value)
                begin
                    $display("%0t: value expected %h actual %h", $time, want.value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last_of_field expected %0d actual %0d",
                             $time, want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser[3:2] !== want.err)
                begin
                    $display("%0t: error_code expected %0d actual %0d",
                             $time, want.err, m_axis_tuser[3:2]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        cfg_buffer_size = '0;
        field_func      = '0;
        read_pos        = '0;
        clear_parse();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_empty_buffer();
        check_field_kinds();
        check_length_limits();
        check_size_change_mid_field();
        check_overlong_varint();
        check_random_buffers();

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
